[hw/rtl/kinematic_bicycle_step_macros.svh]
// assertion macros shared by the vehicle integrator rtl
// no dependencies; the assertions drop out when SYNTHESIS is defined
`ifndef KINEMATIC_BICYCLE_STEP_MACROS_SVH
`define KINEMATIC_BICYCLE_STEP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define KBS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kbs assertion failed");
// next-cycle implication
`define KBS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kbs assertion failed");
`else
`define KBS_ASSERT_IMP(label, clk, rst, ante, cons)
`define KBS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[hw/rtl/kbs_pkg.sv]
// types and constants of the vehicle integrator
// no dependencies
`timescale 1ns / 1ps
package kbs_pkg;

  localparam int MUL_AW = 48;
  localparam int MUL_BW = 32;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  localparam logic [1:0] CMD_STEP    = 2'd0;
  localparam logic [1:0] CMD_ACTUATE = 2'd1;
  localparam logic [1:0] CMD_RESET   = 2'd2;

  localparam logic [1:0] REG_TIME_STEP     = 2'd0;
  localparam logic [1:0] REG_SPEED_GAIN    = 2'd1;
  localparam logic [1:0] REG_INV_WHEELBASE = 2'd2;

  localparam logic signed [32:0] CORDIC_START = 33'sd652032875;
  localparam logic signed [31:0] RAD_TO_TURN  = 32'sd683565276;
  localparam logic signed [20:0] TAN_LIMIT    = 21'sd524288;

  localparam logic [31:0] ATAN_TAB [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic                     start;
    logic signed [MUL_AW-1:0] a;
    logic signed [MUL_BW-1:0] b;
  } mul_req_t;

endpackage

[hw/rtl/kinematic_bicycle_step.sv]
// top level of the fixed-point kinematic bicycle integrator
// depends on kbs_pkg, kbs_mul, kbs_cordic and kinematic_bicycle_step_macros.svh
//
//  channel  | group           | payload
//  ---------+-----------------+--------------------------------------------------
//  input    | s_axis_*        | tuser: command; tdata: target_speed, target_steer
//  output   | m_axis_*        | tdata: pos_x, pos_y, heading, speed, steer_angle
//  config   | cfg_we/index    | cfg_data: time_step, speed_gain, inv_wheelbase
//
// a step tick, from input transfer to valid result, takes ten products in the shared
// bit-serial multiplier, two cordic runs, 19 divider steps for tan (skipped when tan
// saturates) and a load of the output register; actuate, reset and unused commands
// only load the output register
// one item is in work at a time; a full output register stalls the sequencer
// rst is synchronous and clears pose, targets and registers to their defaults
`timescale 1ns / 1ps
`include "kinematic_bicycle_step_macros.svh"
module kinematic_bicycle_step import kbs_pkg::*; #(
  parameter int ANGLE_BITS      = 16,
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,   // target_speed[23:0], target_steer[39:24]
  input  logic [1:0]   s_axis_tuser,   // command[1:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [119:0] m_axis_tdata,   // pos_x, pos_y, heading, speed, steer_angle
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [17:0]  cfg_data
);

  localparam int DIV_STEPS = 19;
  localparam int DCW       = $clog2(DIV_STEPS);

  typedef enum logic [3:0] {
    ST_IDLE, ST_GAIN, ST_GAIN_DT, ST_TRIG_H, ST_X1, ST_X2, ST_Y1, ST_Y2,
    ST_TRIG_S, ST_DIV, ST_R1, ST_R2, ST_R3, ST_R4, ST_EMIT
  } state_t;

  state_t state;

  // configuration
  logic [15:0] time_step;
  logic [15:0] speed_gain;
  logic [17:0] inv_wheelbase;

  // vehicle state and targets
  logic signed [31:0]           car_x, car_y;
  logic [ANGLE_BITS-1:0]        car_heading;
  logic signed [23:0]           car_speed;
  logic signed [ANGLE_BITS-1:0] car_steer;
  logic signed [23:0]           goal_speed;
  logic signed [ANGLE_BITS-1:0] goal_steer;

  // shared units
  mul_req_t                 mreq;
  logic                     mul_done;
  logic signed [MUL_PW-1:0] mp;
  logic                     cor_start;
  logic [31:0]              cor_angle;
  logic                     cor_done;
  logic signed [32:0]       cor_cos, cor_sin;

  // divider for tan
  logic [33:0]        div_r;
  logic [32:0]        div_cm;
  logic [18:0]        div_n, div_q;
  logic [DCW-1:0]     div_cnt;
  logic               tan_neg;
  logic signed [20:0] tan_q;

  logic         out_valid;
  logic [119:0] out_data;

  // input transfer fields
  logic [1:0]         in_cmd;
  logic signed [23:0] in_speed;
  logic signed [15:0] in_steer;
  logic signed [31:0] in_steer32;

  // datapath helpers
  logic signed [MUL_PW-1:0] r16, r28, r30, rdh;
  logic signed [31:0]       inc;
  logic signed [31:0]       spd_sum;
  logic signed [33:0]       dpos;
  logic signed [33:0]       x_sum, y_sum;
  logic signed [24:0]       diff;
  logic [31:0]              head_turn, steer_turn;
  logic [ANGLE_BITS-1:0]    steer_bits;
  logic [32:0]              cmag, smag;
  logic                     tan_sat;
  logic [33:0]              div_t, div_d;
  logic                     div_ge;
  logic [18:0]              q_next;
  logic [20:0]              tmag;
  logic [31:0]              head32;
  logic signed [31:0]       steer32;
  logic                     mul_wait;

  function automatic logic signed [MUL_PW-1:0] rshr(input logic signed [MUL_PW-1:0] v,
                                                   input int unsigned s);
    logic signed [MUL_PW-1:0] t;
    t = (v >>> (s - 1)) + signed'(MUL_PW'(1));
    return t >>> 1;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
    if (v > 32'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -32'sd8388608) begin
      return 24'sh800000;
    end else begin
      return v[23:0];
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -34'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  kbs_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mreq),
    .done (mul_done),
    .prod (mp)
  );

  kbs_cordic #(
    .ITERS (TRIG_ITERATIONS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .angle (cor_angle),
    .done  (cor_done),
    .cos_v (cor_cos),
    .sin_v (cor_sin)
  );

  assign in_cmd     = s_axis_tuser;
  assign in_speed   = s_axis_tdata[23:0];
  assign in_steer   = s_axis_tdata[39:24];
  assign in_steer32 = 32'(in_steer);

  always_comb begin
    // rounded shifts of the current product
    r16 = rshr(mp, 16);
    r28 = rshr(mp, 28);
    r30 = rshr(mp, 30);
    rdh = rshr(mp, 48 - ANGLE_BITS);

    inc     = r28[31:0];
    spd_sum = 32'(car_speed) + inc;
    dpos    = r16[33:0];
    x_sum   = 34'(car_x) + dpos;
    y_sum   = 34'(car_y) + dpos;
    diff    = 25'(goal_speed) - 25'(car_speed);

    // binary angles scaled up to a full 32 bit turn
    head_turn  = 32'(car_heading) << (32 - ANGLE_BITS);
    steer_bits = car_steer;
    steer_turn = 32'(steer_bits) << (32 - ANGLE_BITS);

    // tan magnitude setup; saturate when |sin| >= 8|cos|
    cmag    = cor_cos[32] ? 33'(-cor_cos) : 33'(cor_cos);
    smag    = cor_sin[32] ? 33'(-cor_sin) : 33'(cor_sin);
    tan_sat = {3'b000, smag} >= {cmag, 3'b000};

    // one restoring division step
    div_t  = {div_r[32:0], div_n[18]};
    div_ge = div_t >= {1'b0, div_cm};
    div_d  = div_ge ? (div_t - {1'b0, div_cm}) : div_t;
    q_next = {div_q[17:0], div_ge};
    tmag   = {2'b00, q_next};

    head32  = 32'(car_heading);
    steer32 = 32'(car_steer);
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      time_step     <= 16'd655;
      speed_gain    <= 16'd8192;
      inv_wheelbase <= 18'd24273;
      car_x         <= '0;
      car_y         <= '0;
      car_heading   <= '0;
      car_speed     <= '0;
      car_steer     <= '0;
      goal_speed    <= '0;
      goal_steer    <= '0;
      mreq          <= '0;
      cor_start     <= 1'b0;
      cor_angle     <= '0;
      div_r         <= '0;
      div_cm        <= '0;
      div_n         <= '0;
      div_q         <= '0;
      div_cnt       <= '0;
      tan_neg       <= 1'b0;
      tan_q         <= '0;
      out_valid     <= 1'b0;
      out_data      <= '0;
    end else begin
      mreq.start <= 1'b0;
      cor_start  <= 1'b0;

      if (cfg_we) begin
        case (cfg_index)
          REG_TIME_STEP:     time_step     <= cfg_data[15:0];
          REG_SPEED_GAIN:    speed_gain    <= cfg_data[15:0];
          REG_INV_WHEELBASE: inv_wheelbase <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            state <= ST_EMIT;
            case (in_cmd)
              CMD_STEP: begin
                // speed lag: diff * gain first
                mreq  <= '{start: 1'b1, a: MUL_AW'(diff), b: MUL_BW'(speed_gain)};
                state <= ST_GAIN;
              end
              CMD_ACTUATE: begin
                goal_speed <= in_speed;
                goal_steer <= in_steer32[ANGLE_BITS-1:0];
              end
              CMD_RESET: begin
                car_x       <= '0;
                car_y       <= '0;
                car_heading <= '0;
                car_speed   <= '0;
                car_steer   <= '0;
                goal_speed  <= '0;
                goal_steer  <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_GAIN: begin
          if (mul_done) begin
            mreq  <= '{start: 1'b1, a: mp[MUL_AW-1:0], b: MUL_BW'(time_step)};
            state <= ST_GAIN_DT;
          end
        end
        ST_GAIN_DT: begin
          if (mul_done) begin
            car_speed <= sat24(spd_sum);
            car_steer <= goal_steer;
            // heading from before the tick
            cor_angle <= head_turn;
            cor_start <= 1'b1;
            state     <= ST_TRIG_H;
          end
        end
        ST_TRIG_H: begin
          if (cor_done) begin
            mreq  <= '{start: 1'b1, a: MUL_AW'(cor_cos), b: MUL_BW'(car_speed)};
            state <= ST_X1;
          end
        end
        ST_X1: begin
          if (mul_done) begin
            mreq  <= '{start: 1'b1, a: r30[MUL_AW-1:0], b: MUL_BW'(time_step)};
            state <= ST_X2;
          end
        end
        ST_X2: begin
          if (mul_done) begin
            car_x <= sat32(x_sum);
            mreq  <= '{start: 1'b1, a: MUL_AW'(cor_sin), b: MUL_BW'(car_speed)};
            state <= ST_Y1;
          end
        end
        ST_Y1: begin
          if (mul_done) begin
            mreq  <= '{start: 1'b1, a: r30[MUL_AW-1:0], b: MUL_BW'(time_step)};
            state <= ST_Y2;
          end
        end
        ST_Y2: begin
          if (mul_done) begin
            car_y     <= sat32(y_sum);
            cor_angle <= steer_turn;
            cor_start <= 1'b1;
            state     <= ST_TRIG_S;
          end
        end
        ST_TRIG_S: begin
          if (cor_done) begin
            tan_neg <= cor_sin[32] ^ cor_cos[32];
            if (tan_sat) begin
              tan_q <= (cor_sin[32] ^ cor_cos[32]) ? -TAN_LIMIT : TAN_LIMIT;
              mreq  <= '{start: 1'b1, a: MUL_AW'(car_speed),
                         b: MUL_BW'(inv_wheelbase)};
              state <= ST_R1;
            end else begin
              // quotient fits 19 bits, so the top of the dividend seeds the remainder
              div_r   <= 34'(smag >> 3);
              div_n   <= {smag[2:0], 16'h0000};
              div_cm  <= cmag;
              div_q   <= '0;
              div_cnt <= '0;
              state   <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          div_r   <= div_d;
          div_n   <= div_n << 1;
          div_q   <= q_next;
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DCW'(DIV_STEPS-1)) begin
            tan_q <= tan_neg ? -signed'(tmag) : signed'(tmag);
            mreq  <= '{start: 1'b1, a: MUL_AW'(car_speed), b: MUL_BW'(inv_wheelbase)};
            state <= ST_R1;
          end
        end
        ST_R1: begin
          if (mul_done) begin
            mreq  <= '{start: 1'b1, a: r16[MUL_AW-1:0], b: MUL_BW'(tan_q)};
            state <= ST_R2;
          end
        end
        ST_R2: begin
          if (mul_done) begin
            mreq  <= '{start: 1'b1, a: r16[MUL_AW-1:0], b: MUL_BW'(time_step)};
            state <= ST_R3;
          end
        end
        ST_R3: begin
          if (mul_done) begin
            // radians to binary turns
            mreq  <= '{start: 1'b1, a: r16[MUL_AW-1:0], b: RAD_TO_TURN};
            state <= ST_R4;
          end
        end
        ST_R4: begin
          if (mul_done) begin
            car_heading <= car_heading + rdh[ANGLE_BITS-1:0];
            state       <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!out_valid || m_axis_tready) begin
            out_data  <= {steer32[15:0], car_speed, head32[15:0], car_y, car_x};
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // states that wait on the multiplier
  assign mul_wait = state inside {ST_GAIN, ST_GAIN_DT, ST_X1, ST_X2, ST_Y1, ST_Y2,
                                  ST_R1, ST_R2, ST_R3, ST_R4};

  // products only finish while the sequencer waits on the multiplier
  `KBS_ASSERT_IMP(a_mul_done_wait, clk, rst, mul_done, mul_wait)
  // cordic results only arrive in the two trig waits
  `KBS_ASSERT_IMP(a_cor_done_wait, clk, rst, cor_done, (state == ST_TRIG_H || state == ST_TRIG_S))
  // heading moves only at the end of a tick or on an accepted transfer
  `KBS_ASSERT_NEXT(a_heading_hold, clk, rst, (state != ST_R4 && state != ST_IDLE), $stable(car_heading))
  // a new multiply never starts in the idle or emit state
  `KBS_ASSERT_IMP(a_mul_no_overlap, clk, rst, mreq.start, (state != ST_IDLE && state != ST_EMIT))

endmodule

[hw/rtl/kbs_mul.sv]
// bit-serial signed multiplier, one multiplier bit per cycle
// depends on kbs_pkg
`timescale 1ns / 1ps
module kbs_mul import kbs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  mul_req_t                 req,
  output logic                     done,
  output logic signed [MUL_PW-1:0] prod
);

  localparam int CW = $clog2(MUL_BW);

  logic signed [MUL_AW-1:0] a_reg;
  logic [MUL_BW-1:0]        b_reg;
  logic signed [MUL_AW:0]   acc;
  logic [MUL_BW-1:0]        lo;
  logic [CW-1:0]            cnt;
  logic                     busy;
  logic signed [MUL_AW:0]   a_ext;
  logic signed [MUL_AW:0]   addend;
  logic signed [MUL_AW:0]   sum;

  // sign bit of b carries negative weight
  always_comb begin
    a_ext  = (MUL_AW+1)'(a_reg);
    addend = '0;
    if (b_reg[0]) begin
      addend = (cnt == CW'(MUL_BW-1)) ? -a_ext : a_ext;
    end
    sum = acc + addend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      cnt   <= '0;
      acc   <= '0;
      lo    <= '0;
      a_reg <= '0;
      b_reg <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        a_reg <= req.a;
        b_reg <= req.b;
        acc   <= '0;
        lo    <= '0;
        cnt   <= '0;
      end else if (busy) begin
        acc   <= sum >>> 1;
        lo    <= {sum[0], lo[MUL_BW-1:1]};
        b_reg <= b_reg >> 1;
        cnt   <= cnt + 1'b1;
        if (cnt == CW'(MUL_BW-1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign prod = {acc[MUL_AW-1:0], lo};

endmodule

[hw/rtl/kbs_cordic.sv]
// iterative rotation-mode cordic, one micro-rotation per cycle
// depends on kbs_pkg
`timescale 1ns / 1ps
module kbs_cordic import kbs_pkg::*; #(
  parameter int ITERS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [31:0]        angle,
  output logic               done,
  output logic signed [32:0] cos_v,
  output logic signed [32:0] sin_v
);

  localparam int NIT = (ITERS < 24) ? ITERS : 24;
  localparam int CW  = $clog2(NIT);

  logic signed [32:0] x, y, z;
  logic signed [32:0] xs, ys, at;
  logic signed [32:0] x_n, y_n, z_n;
  logic               neg, busy, flip;
  logic [CW-1:0]      cnt;
  logic [31:0]        a_adj, a_rot;

  // fold the left half plane onto the right half
  always_comb begin
    a_adj = angle + 32'h4000_0000;
    flip  = a_adj[31];
    a_rot = flip ? (angle + 32'h8000_0000) : angle;
  end

  always_comb begin
    xs = x >>> cnt;
    ys = y >>> cnt;
    at = signed'({1'b0, ATAN_TAB[5'(cnt)]});
    if (!z[32]) begin
      x_n = x - ys;
      y_n = y + xs;
      z_n = z - at;
    end else begin
      x_n = x + ys;
      y_n = y - xs;
      z_n = z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      neg  <= 1'b0;
      x    <= '0;
      y    <= '0;
      z    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x    <= CORDIC_START;
        y    <= '0;
        z    <= 33'(signed'(a_rot));
        neg  <= flip;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        x   <= x_n;
        y   <= y_n;
        z   <= z_n;
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NIT-1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign cos_v = neg ? -x : x;
  assign sin_v = neg ? -y : y;

endmodule

[test/kbs_checker.sv]
// scoreboard for the vehicle integrator: watches both streams and the register port
// predicts each pose from its own fixed-point copy of the state; uses kbs_pkg
`timescale 1ns / 1ps
module kbs_checker import kbs_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,   // target_speed[23:0], target_steer[39:24]
  input  logic [1:0]   s_axis_tuser,   // command[1:0]
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [119:0] m_axis_tdata,   // pos_x, pos_y, heading, speed, steer_angle
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [17:0]  cfg_data,
  output int           errors,
  output int           pending
);

  typedef struct packed {
    logic signed [15:0] steer;
    logic signed [23:0] speed;
    logic        [15:0] heading;
    logic signed [31:0] y;
    logic signed [31:0] x;
  } pose_t;

  pose_t  poses_due[$];
  longint dt, gain, inv_wb;
  longint px, py, spd, steer, goal_spd, goal_steer;
  logic [15:0] hdg;

  function automatic longint round_shr(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(longint v, int w);
    longint hi, lo;
    hi = (64'sd1 <<< (w - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  // rotation-mode cordic on a 32-bit turn angle, back half folded forward
  function automatic void sin_cos(input logic [31:0] a, output longint c, output longint s);
    logic   flip;
    longint x, y, z, t;
    flip = 1'b0;
    x = 652032875;
    y = 0;
    if (((a + 32'h40000000) & 32'h80000000) != 0) begin
      a = a + 32'h80000000;
      flip = 1'b1;
    end
    z = longint'($signed(a));
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z = z - longint'(ATAN_TAB[i]);
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z = z + longint'(ATAN_TAB[i]);
      end
      x = t;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint tan_q16(logic [15:0] ang);
    longint c, s, cm, sm, t;
    sin_cos({ang, 16'h0}, c, s);
    cm = c < 0 ? -c : c;
    sm = s < 0 ? -s : s;
    if (cm == 0 || sm >= 8 * cm) t = 524288;
    else t = (sm <<< 16) / cm;
    return ((s < 0) != (c < 0)) ? -t : t;
  endfunction

  task automatic advance_tick();
    longint c, s, p, rad;
    spd = clamp(spd + round_shr((goal_spd - spd) * gain * dt, 28), 24);
    steer = goal_steer;
    sin_cos({hdg, 16'h0}, c, s);
    p = round_shr(spd * c, 30);
    px = clamp(px + round_shr(p * dt, 16), 32);
    p = round_shr(spd * s, 30);
    py = clamp(py + round_shr(p * dt, 16), 32);
    rad = round_shr(spd * inv_wb, 16);
    rad = round_shr(rad * tan_q16(steer[15:0]), 16);
    rad = round_shr(rad * dt, 16);
    hdg = hdg + 16'(round_shr(rad * 683565276, 32));
  endtask

  task automatic clear_pose();
    px = 0; py = 0; spd = 0; steer = 0; goal_spd = 0; goal_steer = 0;
    hdg = '0;
  endtask

  always @(posedge clk) begin
    pose_t want, got;
    if (rst) begin
      dt = 655; gain = 8192; inv_wb = 24273;
      clear_pose();
      poses_due.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TIME_STEP:     dt = cfg_data[15:0];
          REG_SPEED_GAIN:    gain = cfg_data[15:0];
          REG_INV_WHEELBASE: inv_wb = cfg_data;
          default: ;  // no such register
        endcase
      end
      // input transfer: update the state, queue the pose it leaves behind
      if (s_axis_tvalid && s_axis_tready) begin
        case (s_axis_tuser)
          CMD_STEP: advance_tick();
          CMD_ACTUATE: begin
            goal_spd = longint'($signed(s_axis_tdata[23:0]));
            goal_steer = longint'($signed(s_axis_tdata[39:24]));
          end
          CMD_RESET: clear_pose();
          default: ;  // unused code just reports the pose
        endcase
        want.x = px[31:0];
        want.y = py[31:0];
        want.heading = hdg;
        want.speed = spd[23:0];
        want.steer = steer[15:0];
        poses_due.push_back(want);
      end
      // output transfer: compare with the oldest pose due
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (poses_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected pose %h", got);
        end else begin
          want = poses_due.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.heading !== want.heading ||
              got.speed !== want.speed || got.steer !== want.steer) begin
            errors++;
            if (errors <= 10)
              $display("pose mismatch: x %h/%h y %h/%h hdg %h/%h spd %h/%h str %h/%h",
                       want.x, got.x, want.y, got.y, want.heading, got.heading,
                       want.speed, got.speed, want.steer, got.steer);
          end
        end
      end
    end
    pending = poses_due.size();
  end

endmodule

[test/tb_kinematic_bicycle_step.sv]
// stimulus top for the vehicle integrator: clock, reset, commands, register writes
// depends on kbs_pkg, kinematic_bicycle_step and kbs_checker
`timescale 1ns / 1ps
module tb_kinematic_bicycle_step import kbs_pkg::*;;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [1:0] REG_NONE   = 2'd3;
  localparam int DRAIN_CYCLES = 400;
  localparam int STALL_LIMIT  = 20000;  // longest quiet stretch allowed

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [39:0]  s_axis_tdata;   // target_speed[23:0], target_steer[39:24]
  logic [1:0]   s_axis_tuser;   // command[1:0]
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [119:0] m_axis_tdata;   // pos_x, pos_y, heading, speed, steer_angle
  logic         cfg_we;
  logic [1:0]   cfg_index;
  logic [17:0]  cfg_data;
  int           errors;
  int           pending;
  int           quiet_cycles;
  logic         no_gaps;     // both sides run without idling
  logic         long_hold;   // receiver holds off for a long stretch

  kinematic_bicycle_step dut (.*);

  kbs_checker u_checker (.*);

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // watchdog: any transfer resets the count
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: random stall per result, one long hold-off on request
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(negedge rst);
    forever begin
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        repeat (3000) @(posedge clk);
        long_hold = 1'b0;
      end
      stall = no_gaps ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  // one command transfer after a random gap
  task automatic send(input logic [1:0] cmd, input logic [23:0] spd, input logic [15:0] str);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {str, spd};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // registers change only with the block idle
  task automatic set_regs(input logic [17:0] ts, input logic [17:0] g, input logic [17:0] iw);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= REG_TIME_STEP; cfg_data <= ts; @(posedge clk);
    cfg_index <= REG_SPEED_GAIN; cfg_data <= g; @(posedge clk);
    cfg_index <= REG_INV_WHEELBASE; cfg_data <= iw; @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [23:0] pick_speed();
    case ($urandom_range(0, 3))
      0: return 24'($urandom);
      1: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      default: return 24'($signed(20'($urandom)));
    endcase
  endfunction

  // mostly ticks, some actuates, a few resets and unused codes
  task automatic random_run(input int count);
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 4) send(CMD_RESET, 24'($urandom), 16'($urandom));
      else if (r < 8) send(CMD_UNUSED, 24'($urandom), 16'($urandom));
      else if (r < 25) send(CMD_ACTUATE, pick_speed(), 16'($urandom));
      else send(CMD_STEP, 24'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = CMD_STEP;
    cfg_we = 1'b0;
    cfg_index = REG_TIME_STEP;
    cfg_data = '0;
    no_gaps = 1'b0;
    long_hold = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: defaults, field extremes, steering at and past a quarter turn
    send(CMD_STEP, 24'h000000, 16'h0000);
    send(CMD_ACTUATE, 24'h7FFFFF, 16'h7FFF);
    send(CMD_STEP, 24'h000000, 16'h0000);
    send(CMD_STEP, 24'hFFFFFF, 16'hFFFF);
    send(CMD_ACTUATE, 24'h800000, 16'h8000);
    send(CMD_STEP, 24'h000000, 16'h0000);
    send(CMD_ACTUATE, 24'h010000, 16'h4000);   // cos is zero, tan saturates
    send(CMD_STEP, 24'h000000, 16'h0000);
    send(CMD_ACTUATE, 24'h020000, 16'h6000);   // past a quarter turn
    send(CMD_STEP, 24'h000000, 16'h0000);
    send(CMD_UNUSED, 24'hFFFFFF, 16'hFFFF);
    send(CMD_RESET, 24'h000000, 16'h0000);
    // zero step freezes position, heading and speed; a write to a missing register is dropped
    set_regs(18'd0, 18'd8192, 18'd24273);
    drain();
    cfg_we <= 1'b1; cfg_index <= REG_NONE; cfg_data <= 18'h3FFFF;
    @(posedge clk);
    cfg_we <= 1'b0;
    send(CMD_ACTUATE, 24'h050000, 16'h1000);
    send(CMD_STEP, 24'h000000, 16'h0000);
    // huge gain times step overshoots and saturates
    set_regs(18'd65535, 18'd65535, 18'd262143);
    send(CMD_ACTUATE, 24'h7FFFFF, 16'h2000);
    send(CMD_STEP, 24'h000000, 16'h0000);
    send(CMD_ACTUATE, 24'h800000, 16'hE000);
    send(CMD_STEP, 24'h000000, 16'h0000);
    send(CMD_STEP, 24'h000000, 16'h0000);
    set_regs(18'd1, 18'd0, 18'd1);
    send(CMD_ACTUATE, 24'h7FFFFF, 16'h7FFF);
    send(CMD_STEP, 24'h000000, 16'h0000);

    // random phases over several register settings
    set_regs(18'd655, 18'd8192, 18'd24273);
    random_run(230);
    set_regs(18'd3000, 18'd4096, 18'd100000);
    long_hold = 1'b1;                 // output side backs up the block
    no_gaps = 1'b1;
    random_run(40);
    no_gaps = 1'b0;
    random_run(190);
    set_regs(18'd65535, 18'd65535, 18'd262143);
    random_run(110);
    drain();                          // sender waits out every result
    random_run(110);
    set_regs(18'd1, 18'd0, 18'd1);
    random_run(220);
    set_regs(18'($urandom_range(1, 65535)), 18'($urandom_range(0, 65535)),
             18'($urandom_range(1, 262143)));
    random_run(230);
    set_regs(18'd300, 18'd12000, 18'd50000);
    random_run(250);

    drain();
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/kbs_pkg.sv
hw/rtl/kbs_mul.sv
hw/rtl/kbs_cordic.sv
hw/rtl/kinematic_bicycle_step.sv
test/kbs_checker.sv
test/tb_kinematic_bicycle_step.sv
